### hw/rtl/buddy_block_allocator_assert.svh
// buddy_block_allocator_assert.svh: assertion macros for the buddy allocator checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define BBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator assertion failed");

// next-cycle implication, off during reset
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator assertion failed");

// next-cycle implication that also holds across reset
`define BBA_ASSERT_ALW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("buddy allocator assertion failed");

`endif

### hw/rtl/bba_pkg.sv
// bba_pkg: shared constants and types of the buddy block allocator
// no dependencies; imported by the allocator and its checker
package bba_pkg;

   localparam int N_UNITS  = 4096;
   localparam int UNIT_W   = 12;
   localparam int LINK_W   = 13;
   localparam int N_LEVELS = 16;
   localparam int LVL_W    = 4;

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(N_UNITS);

   // transaction opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_BLOCK = 2'd2;
   localparam logic [1:0] ST_BAD_PTR  = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_MIN_ORDER = 3'd0;
   localparam logic [2:0] CSR_MAX_ORDER = 3'd1;
   localparam logic [2:0] CSR_TOP_BLKS  = 3'd2;
   localparam logic [2:0] CSR_POOL_BASE = 3'd3;

   // per-unit block descriptor
   typedef struct packed {
      logic       start;
      logic       in_use;
      logic [4:0] order;
   } meta_type;

endpackage

### hw/rtl/buddy_block_allocator.sv
// buddy_block_allocator: binary buddy allocator with per-order free lists
// depends on bba_pkg; memories are held inside this module
//
// Usage: raise start with req_opcode (0 allocate, 1 free), req_request_bytes and
// req_release_address while busy is low; the transaction is taken at that edge.
// One result per transaction appears on rsp_grant_address and rsp_status for a
// single cycle, flagged by rsp_valid, and busy drops in that same cycle. The
// receiver cannot stall; a result must be taken when it is shown.
// An allocate checks the size, rounds it up one order step at a time, probes
// the free lists upward and splits the block it finds down to size; a bad size
// answers after the size check. A free checks the pointer, then merges with
// free buddies order by order; a bad pointer answers as soon as a check fails.
// All work goes through one shared shifter and single-ported unit memories,
// one access per cycle, so one transaction is handled at a time.
// Reset and every write to registers 0..3 rebuild the pool: a clearing pass
// walks all 4096 units while busy stays high. csr_we writes are accepted at
// any edge and restart the pass.
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_grant_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [4:0] S_CFG   = 5'd0;
   localparam logic [4:0] S_CLR   = 5'd1;
   localparam logic [4:0] S_IDLE  = 5'd2;
   localparam logic [4:0] A_LIM   = 5'd3;
   localparam logic [4:0] A_K     = 5'd4;
   localparam logic [4:0] A_SRCH  = 5'd5;
   localparam logic [4:0] A_SPLIT = 5'd6;
   localparam logic [4:0] A_FIN   = 5'd7;
   localparam logic [4:0] F_MSK   = 5'd8;
   localparam logic [4:0] F_CHK   = 5'd9;
   localparam logic [4:0] F_RD    = 5'd10;
   localparam logic [4:0] F_LOOP  = 5'd11;
   localparam logic [4:0] F_BUD   = 5'd12;
   localparam logic [4:0] F_MRG   = 5'd13;
   localparam logic [4:0] F_ORD   = 5'd14;
   localparam logic [4:0] F_DONE  = 5'd15;
   localparam logic [4:0] P0      = 5'd16;
   localparam logic [4:0] P1      = 5'd17;
   localparam logic [4:0] U0      = 5'd18;
   localparam logic [4:0] U1      = 5'd19;
   localparam logic [4:0] U2      = 5'd20;
   localparam logic [4:0] U3      = 5'd21;

   // configuration and derived pool geometry
   logic [4:0]  cfg_min_ff, cfg_min_in, cfg_max_ff, cfg_max_in;
   logic [12:0] cfg_top_ff, cfg_top_in;
   logic [31:0] cfg_base_ff, cfg_base_in;
   logic [4:0]  eff_min_ff, eff_min_in, eff_max_ff, eff_max_in;
   logic [LVL_W-1:0]  top_lvl_ff, top_lvl_in;
   logic [LINK_W-1:0] span_ff, span_in, units_ff, units_in;

   // sequencer and working registers
   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [LINK_W-1:0] cnt_ff, cnt_in;
   logic [31:0] work_ff, work_in;
   logic [4:0]  k_ff, k_in, o_ff, o_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in, j_ff, j_in, sl_ff, sl_in;
   logic [UNIT_W-1:0] u_ff, u_in, v_ff, v_in, su_ff, su_in;
   logic        side_ff, side_in;
   logic [LINK_W-1:0] un_ff, un_in, up_ff, up_in, ph_ff, ph_in;
   logic [LINK_W-1:0] head_ff [N_LEVELS];
   logic [LINK_W-1:0] head_in [N_LEVELS];

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_grant_ff, rsp_grant_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // unit memories
   meta_type          meta_mem_ff [N_UNITS];
   logic [LINK_W-1:0] next_mem_ff [N_UNITS];
   logic [LINK_W-1:0] prev_mem_ff [N_UNITS];
   meta_type          meta_rd_ff;
   logic [LINK_W-1:0] next_rd_ff, prev_rd_ff;
   logic [UNIT_W-1:0] mem_addr;
   logic              meta_we, next_we, prev_we;
   meta_type          meta_wd;
   logic [LINK_W-1:0] next_wd, prev_wd;

   // shared shifter
   logic [31:0] sh_val, sh_res;
   logic [4:0]  sh_amt;
   logic        sh_left;

   // helpers
   logic [LVL_W-1:0]  lvl_sel, lvl_o, j_dn;
   logic [LINK_W-1:0] head_rd, v_sum, blk_mask;
   logic              clr_blk;

   // geometry derived from the registers
   logic [4:0]  c_mn, c_mx;
   logic [5:0]  c_mx_cap, c_exp;
   logic [LVL_W-1:0] c_lvl;
   logic [13:0] c_top, c_lim1, c_lim2;
   logic [LINK_W-1:0] c_span, c_units;

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_grant_address = rsp_grant_ff;
   assign rsp_status        = rsp_status_ff;

   assign sh_res   = sh_left ? (sh_val << sh_amt) : (sh_val >> sh_amt);
   assign head_rd  = head_ff[lvl_sel];
   assign lvl_o    = LVL_W'(o_ff - eff_min_ff);
   assign j_dn     = j_ff - LVL_W'(1);
   assign blk_mask = span_ff - LINK_W'(1);
   assign clr_blk  = ((cnt_ff & blk_mask) == '0) && (cnt_ff < units_ff);

   // clamp the register values into a legal pool shape
   always_comb begin
      c_mn = (cfg_min_ff < 5'd4) ? 5'd4 : ((cfg_min_ff > 5'd30) ? 5'd30 : cfg_min_ff);
      c_mx = cfg_max_ff;
      if (c_mx <= c_mn) begin
         c_mx = c_mn + 5'd1;
      end
      c_mx_cap = {1'b0, c_mn} + 6'd12;
      if ({1'b0, c_mx} > c_mx_cap) begin
         c_mx = c_mx_cap[4:0];
      end
      c_lvl  = LVL_W'(c_mx - c_mn);
      c_top  = (cfg_top_ff == '0) ? 14'd1 : {1'b0, cfg_top_ff};
      c_lim1 = 14'(N_UNITS) >> c_lvl;
      c_exp  = 6'd32 - {1'b0, c_mx};
      c_lim2 = (c_exp >= 6'd13) ? 14'd8192 : (14'd1 << c_exp[3:0]);
      if (c_top > c_lim1) begin
         c_top = c_lim1;
      end
      if (c_top > c_lim2) begin
         c_top = c_lim2;
      end
      c_span  = LINK_W'(1) << c_lvl;
      c_units = LINK_W'(c_top << c_lvl);
   end

   // sequencer
   always_comb begin
      cfg_min_in = cfg_min_ff; cfg_max_in = cfg_max_ff;
      cfg_top_in = cfg_top_ff; cfg_base_in = cfg_base_ff;
      eff_min_in = eff_min_ff; eff_max_in = eff_max_ff; top_lvl_in = top_lvl_ff;
      span_in = span_ff; units_in = units_ff;
      state_in = state_ff; ret_in = ret_ff; cnt_in = cnt_ff; work_in = work_ff;
      k_in = k_ff; o_in = o_ff; lvl_in = lvl_ff; j_in = j_ff; sl_in = sl_ff;
      u_in = u_ff; v_in = v_ff; su_in = su_ff; side_in = side_ff;
      un_in = un_ff; up_in = up_ff; ph_in = ph_ff;
      head_in = head_ff;
      rsp_valid_in = 1'b0; rsp_grant_in = rsp_grant_ff; rsp_status_in = rsp_status_ff;
      mem_addr = u_ff;
      meta_we = 1'b0; meta_wd = '0;
      next_we = 1'b0; next_wd = NIL_LINK;
      prev_we = 1'b0; prev_wd = NIL_LINK;
      sh_val = '0; sh_amt = '0; sh_left = 1'b1;
      lvl_sel = j_ff;
      v_sum = '0;

      unique case (state_ff)
         S_CFG: begin
            eff_min_in = c_mn;
            eff_max_in = c_mx;
            top_lvl_in = c_lvl;
            span_in    = c_span;
            units_in   = c_units;
            for (int i = 0; i < N_LEVELS; i++) begin
               head_in[i] = NIL_LINK;
            end
            head_in[c_lvl] = c_units - c_span;
            cnt_in   = '0;
            state_in = S_CLR;
         end
         // clearing pass: top blocks linked into one list, highest address at the front
         S_CLR: begin
            mem_addr = cnt_ff[UNIT_W-1:0];
            meta_we  = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            meta_wd  = '{start: clr_blk, in_use: 1'b0, order: clr_blk ? eff_max_ff : 5'd0};
            if (clr_blk && cnt_ff != '0) begin
               next_wd = cnt_ff - span_ff;
            end
            if (clr_blk && (cnt_ff + span_ff) < units_ff) begin
               prev_wd = cnt_ff + span_ff;
            end
            cnt_in = cnt_ff + LINK_W'(1);
            if (cnt_ff == LINK_W'(N_UNITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_opcode == OP_FREE) begin
                  work_in  = req_release_address - 32'd8 - cfg_base_ff;
                  state_in = F_MSK;
               end else begin
                  work_in  = req_request_bytes;
                  state_in = A_LIM;
               end
            end
         end
         // size check against the largest block
         A_LIM: begin
            sh_val = 32'd1;
            sh_amt = eff_max_ff;
            if (work_ff == '0 || work_ff > (sh_res - 32'd16)) begin
               rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_BAD_SIZE;
               state_in = S_IDLE;
            end else begin
               work_in  = work_ff + 32'd15;
               k_in     = eff_min_ff;
               state_in = A_K;
            end
         end
         // round up to a power of two, one order per cycle
         A_K: begin
            sh_val  = work_ff;
            sh_amt  = k_ff;
            sh_left = 1'b0;
            if (sh_res != '0) begin
               k_in = k_ff + 5'd1;
            end else begin
               lvl_in   = LVL_W'(k_ff - eff_min_ff);
               j_in     = LVL_W'(k_ff - eff_min_ff);
               state_in = A_SRCH;
            end
         end
         // probe free lists upward
         A_SRCH: begin
            lvl_sel = j_ff;
            if (j_ff > top_lvl_ff) begin
               rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_NO_BLOCK;
               state_in = S_IDLE;
            end else if (head_rd == NIL_LINK) begin
               j_in = j_ff + LVL_W'(1);
            end else begin
               u_in     = head_rd[UNIT_W-1:0];
               su_in    = head_rd[UNIT_W-1:0];
               sl_in    = j_ff;
               ret_in   = A_SPLIT;
               state_in = U0;
            end
         end
         // split off upper halves
         A_SPLIT: begin
            sh_val = 32'd1;
            sh_amt = {1'b0, j_dn};
            v_sum  = {1'b0, u_ff} + sh_res[LINK_W-1:0];
            if (j_ff > lvl_ff && v_sum < LINK_W'(N_UNITS)) begin
               mem_addr = v_sum[UNIT_W-1:0];
               meta_we  = 1'b1;
               meta_wd  = '{start: 1'b1, in_use: 1'b0, order: eff_min_ff + {1'b0, j_dn}};
               j_in     = j_dn;
               sl_in    = j_dn;
               su_in    = v_sum[UNIT_W-1:0];
               ret_in   = A_SPLIT;
               state_in = P0;
            end else begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            mem_addr = u_ff;
            meta_we  = 1'b1;
            meta_wd  = '{start: 1'b1, in_use: 1'b1, order: k_ff};
            sh_val   = {20'd0, u_ff};
            sh_amt   = eff_min_ff;
            rsp_valid_in = 1'b1;
            rsp_grant_in = cfg_base_ff + sh_res + 32'd8;
            rsp_status_in = ST_OK;
            state_in = S_IDLE;
         end
         // free: alignment check
         F_MSK: begin
            sh_val = 32'hFFFF_FFFF;
            sh_amt = eff_min_ff;
            if ((work_ff & ~sh_res) != '0) begin
               rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_BAD_PTR;
               state_in = S_IDLE;
            end else begin
               state_in = F_CHK;
            end
         end
         F_CHK: begin
            sh_val  = work_ff;
            sh_amt  = eff_min_ff;
            sh_left = 1'b0;
            if (sh_res >= {19'd0, units_ff}) begin
               rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_BAD_PTR;
               state_in = S_IDLE;
            end else begin
               u_in     = sh_res[UNIT_W-1:0];
               mem_addr = sh_res[UNIT_W-1:0];
               state_in = F_RD;
            end
         end
         F_RD: begin
            if (!meta_rd_ff.start || !meta_rd_ff.in_use) begin
               rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_BAD_PTR;
               state_in = S_IDLE;
            end else begin
               mem_addr = u_ff;
               meta_we  = 1'b1;
               meta_wd  = '{start: 1'b1, in_use: 1'b0, order: meta_rd_ff.order};
               o_in     = meta_rd_ff.order;
               state_in = F_LOOP;
            end
         end
         // look at the buddy of the current block
         F_LOOP: begin
            sh_val = 32'd1;
            sh_amt = {1'b0, lvl_o};
            if (o_ff >= eff_max_ff) begin
               sl_in = lvl_o; su_in = u_ff; ret_in = F_DONE; state_in = P0;
            end else if ((u_ff & sh_res[UNIT_W-1:0]) == '0) begin
               v_sum = {1'b0, u_ff} + sh_res[LINK_W-1:0];
               if (v_sum >= units_ff) begin
                  sl_in = lvl_o; su_in = u_ff; ret_in = F_DONE; state_in = P0;
               end else begin
                  v_in     = v_sum[UNIT_W-1:0];
                  side_in  = 1'b0;
                  mem_addr = v_sum[UNIT_W-1:0];
                  state_in = F_BUD;
               end
            end else begin
               v_in     = u_ff - sh_res[UNIT_W-1:0];
               side_in  = 1'b1;
               mem_addr = u_ff - sh_res[UNIT_W-1:0];
               state_in = F_BUD;
            end
         end
         F_BUD: begin
            if (!meta_rd_ff.start || meta_rd_ff.in_use || meta_rd_ff.order != o_ff) begin
               sl_in = lvl_o; su_in = u_ff; ret_in = F_DONE; state_in = P0;
            end else begin
               sl_in = lvl_o; su_in = v_ff; ret_in = F_MRG; state_in = U0;
            end
         end
         // the upper block of the pair stops being a block start
         F_MRG: begin
            meta_we = 1'b1;
            meta_wd = '{start: 1'b0, in_use: 1'b0, order: o_ff};
            if (side_ff) begin
               mem_addr = u_ff;
               u_in     = v_ff;
            end else begin
               mem_addr = v_ff;
            end
            state_in = F_ORD;
         end
         F_ORD: begin
            mem_addr = u_ff;
            meta_we  = 1'b1;
            meta_wd  = '{start: 1'b1, in_use: 1'b0, order: o_ff + 5'd1};
            o_in     = o_ff + 5'd1;
            state_in = F_LOOP;
         end
         F_DONE: begin
            rsp_valid_in = 1'b1; rsp_grant_in = '0; rsp_status_in = ST_OK;
            state_in = S_IDLE;
         end
         // push su at the front of list sl
         P0: begin
            lvl_sel  = sl_ff;
            mem_addr = su_ff;
            next_we  = 1'b1;
            next_wd  = head_rd;
            prev_we  = 1'b1;
            prev_wd  = NIL_LINK;
            head_in[sl_ff] = {1'b0, su_ff};
            ph_in    = head_rd;
            state_in = (head_rd != NIL_LINK) ? P1 : ret_ff;
         end
         P1: begin
            mem_addr = ph_ff[UNIT_W-1:0];
            prev_we  = 1'b1;
            prev_wd  = {1'b0, su_ff};
            state_in = ret_ff;
         end
         // unlink su from list sl
         U0: begin
            mem_addr = su_ff;
            state_in = U1;
         end
         U1: begin
            up_in = prev_rd_ff;
            un_in = next_rd_ff;
            if (prev_rd_ff != NIL_LINK) begin
               mem_addr = prev_rd_ff[UNIT_W-1:0];
               next_we  = 1'b1;
               next_wd  = next_rd_ff;
            end else begin
               head_in[sl_ff] = next_rd_ff;
            end
            state_in = U2;
         end
         U2: begin
            if (un_ff != NIL_LINK) begin
               mem_addr = un_ff[UNIT_W-1:0];
               prev_we  = 1'b1;
               prev_wd  = up_ff;
            end
            state_in = U3;
         end
         U3: begin
            mem_addr = su_ff;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            state_in = ret_ff;
         end
         default: begin
            state_in = S_CFG;
         end
      endcase

      // register writes rebuild the pool
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_ORDER: begin
               cfg_min_in = csr_wdata[4:0];
               state_in = S_CFG;
            end
            CSR_MAX_ORDER: begin
               cfg_max_in = csr_wdata[4:0];
               state_in = S_CFG;
            end
            CSR_TOP_BLKS: begin
               cfg_top_in = csr_wdata[12:0];
               state_in = S_CFG;
            end
            CSR_POOL_BASE: begin
               cfg_base_in = csr_wdata;
               state_in = S_CFG;
            end
            default: begin
            end
         endcase
      end
   end

   // control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CFG;
         rsp_valid_ff <= 1'b0;
         cfg_min_ff   <= 5'd5;
         cfg_max_ff   <= 5'd12;
         cfg_top_ff   <= 13'd1;
         cfg_base_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_min_ff   <= cfg_min_in;
         cfg_max_ff   <= cfg_max_in;
         cfg_top_ff   <= cfg_top_in;
         cfg_base_ff  <= cfg_base_in;
      end
      eff_min_ff <= eff_min_in; eff_max_ff <= eff_max_in; top_lvl_ff <= top_lvl_in;
      span_ff <= span_in; units_ff <= units_in;
      ret_ff <= ret_in; cnt_ff <= cnt_in; work_ff <= work_in;
      k_ff <= k_in; o_ff <= o_in; lvl_ff <= lvl_in; j_ff <= j_in; sl_ff <= sl_in;
      u_ff <= u_in; v_ff <= v_in; su_ff <= su_in; side_ff <= side_in;
      un_ff <= un_in; up_ff <= up_in; ph_ff <= ph_in;
      head_ff <= head_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   // unit memories, one shared address, registered read
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem_ff[mem_addr] <= meta_wd;
      end
      if (next_we) begin
         next_mem_ff[mem_addr] <= next_wd;
      end
      if (prev_we) begin
         prev_mem_ff[mem_addr] <= prev_wd;
      end
      meta_rd_ff <= meta_mem_ff[mem_addr];
      next_rd_ff <= next_mem_ff[mem_addr];
      prev_rd_ff <= prev_mem_ff[mem_addr];
   end

endmodule

### hw/rtl/bba_checker.sv
// bba_checker: port-level assertions for the buddy block allocator
// depends on bba_pkg and buddy_block_allocator_assert.svh; bound into buddy_block_allocator
`include "buddy_block_allocator_assert.svh"

module bba_checker
   import bba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_grant_address,
   input logic [1:0]  rsp_status
);

   // reset always starts the clearing pass
   `BBA_ASSERT_ALW(a_reset_busy, clock, reset, busy)

   // an accepted transaction keeps the block busy
   `BBA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)

   // a result only ends a busy stretch
   `BBA_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy) && !busy)

   // failed transactions grant no address
   `BBA_ASSERT_IMP(a_fail_no_grant, clock, reset, rsp_valid && rsp_status != ST_OK,
                   rsp_grant_address == 32'd0)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
